// ----- sv/hmtd_pkg.sv -----
// ============================================================================
// hmtd_pkg - shared definitions for the multilevel table Huffman decoder
// Types, constants and entry helpers used by the controller, datapath and top.
// ============================================================================
`default_nettype none

package hmtd_pkg;

    localparam int LOOKUP_BITS     = 8;
    localparam int MAX_CODE_LENGTH = 16;
    localparam int SUBTABLE_COUNT  = 64;

    localparam int SLOTS   = 1 << LOOKUP_BITS;
    localparam int LEVEL_W = 7;
    localparam int IDX_W   = LOOKUP_BITS;
    localparam int ADDR_W  = LEVEL_W + IDX_W;
    localparam int DEPTH   = (SUBTABLE_COUNT + 1) * SLOTS;
    localparam int ENTRY_W = 22;
    localparam int CNT_W   = 5;
    localparam int LEN_W   = 5;
    localparam int SYM_W   = 16;
    localparam int CODE_W  = 16;

    // Entry tags, bits 1..0 of a table entry
    localparam logic [1:0] TAG_LINK  = 2'd0;
    localparam logic [1:0] TAG_LEAF  = 2'd1;
    localparam logic [1:0] TAG_EMPTY = 2'd3;

    localparam logic [ENTRY_W-1:0] EMPTY_ENTRY = {{(ENTRY_W-2){1'b0}}, TAG_EMPTY};

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_FEED  = 2'd2,
        CMD_END   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_SYMBOL    = 3'd0,
        ST_INVALID   = 3'd1,
        ST_CLASH     = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_DONE      = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_LD_START,
        S_LD_RD,
        S_LD_EX,
        S_LD_CHK,
        S_LD_WR,
        S_FD_RD,
        S_FD_EX,
        S_FD_FLUSH,
        S_END_START,
        S_END_RD,
        S_END_EX
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SWEEP,
        OP_CAPTURE,
        OP_LD_RD,
        OP_LD_ALLOC,
        OP_LD_FOLLOW,
        OP_CHK,
        OP_WR,
        OP_FD_RD,
        OP_FD_EX,
        OP_FD_FLUSH,
        OP_END_RD,
        OP_END_EX,
        OP_END_FIN
    } t_dp_op;

    typedef struct packed {
        logic [1:0]        command;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [SYM_W-1:0]  symbol_in;
        logic [7:0]        data_byte;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] symbol_out;
        logic [2:0]       status;
        logic             last;
    } t_out_item;

    typedef struct packed {
        t_dp_op  op;
        logic    emit;
        t_status status;
        logic    last;
    } t_dp_cmd;

    typedef struct packed {
        logic       sweep_last;
        logic       len_zero;
        logic       len_over;
        logic       len_long;
        logic [1:0] rd_tag;
        logic       link_ok;
        logic       used_full;
        logic       rem_long;
        logic       chk_bad;
        logic       chk_done;
        logic       wr_last;
        logic       fd_leaf;
        logic       fd_link;
        logic       fd_next_lt8;
        logic       end_zero;
        logic       end_fits;
        logic       end_next_zero;
        logic       level_top;
    } t_dp_stat;

    // Leaf code length, out-of-range lengths read as a full lookup
    function automatic logic [3:0] leaf_len(input logic [ENTRY_W-1:0] e);
        logic [3:0] l;
        l = e[21:18];
        return ((l == 4'd0) || (l > 4'(LOOKUP_BITS))) ? 4'(LOOKUP_BITS) : l;
    endfunction

    // Subtable number of a link, zero when it points nowhere usable
    function automatic logic [LEVEL_W-1:0] link_target(input logic [ENTRY_W-1:0] e);
        logic [LEVEL_W-1:0] lv;
        lv = e[LEVEL_W+1:2];
        return ((lv == '0) || (lv > LEVEL_W'(SUBTABLE_COUNT))) ? '0 : lv;
    endfunction

endpackage

`default_nettype wire

// ----- sv/hmtd_ram.sv -----
// ============================================================================
// hmtd_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module hmtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/hmtd_datapath.sv -----
// ============================================================================
// hmtd_datapath - table store, bit buffer and load/decode arithmetic
// Executes one controller operation per cycle and reports status back.
// ============================================================================
`default_nettype none

module hmtd_datapath
    import hmtd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_stat       o_stat,
    output logic           o_strobe,
    output t_out_item      o_result
);

    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [LEVEL_W-1:0] r_used, n_used;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [LEVEL_W-1:0] r_lvl, n_lvl;
    logic [15:0]        r_buf, n_buf;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CODE_W-1:0]  r_code, n_code;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic [IDX_W:0]     r_j, n_j;
    logic               r_pend, n_pend;
    logic               r_strobe, n_strobe;
    t_out_item          r_res, n_res;
    t_out_item          r_hold, n_hold;
    logic               r_hold_v, n_hold_v;

    logic                we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [ENTRY_W-1:0]  wdata, rd_data;

    logic [LEN_W-1:0]    walk_rem;
    logic [IDX_W-1:0]    walk_idx;
    logic [CODE_W-1:0]   walk_mask;
    logic [3:0]          fill_xbits;
    logic [IDX_W:0]      fill_count;
    logic [IDX_W-1:0]    fill_base, fill_idx;
    logic [2:0]          fd_sh, end_sh;
    logic [IDX_W-1:0]    fd_idx, end_idx;
    logic [3:0]          rd_len;
    logic [LEVEL_W-1:0]  rd_link;
    logic [CNT_W-1:0]    fd_next, end_next;
    logic                fd_leaf, fd_link;
    logic [LEVEL_W-1:0]  used_inc;
    logic [CODE_W-1:0]   in_mask;
    t_out_item           emit_res;

    hmtd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_comb begin
        walk_rem   = r_len - LEN_W'(LOOKUP_BITS);
        walk_idx   = IDX_W'(r_code >> walk_rem);
        walk_mask  = CODE_W'((17'h1 << walk_rem) - 17'h1);
        fill_xbits = 4'(LOOKUP_BITS) - r_len[3:0];
        fill_count = (IDX_W+1)'(1) << fill_xbits;
        fill_base  = IDX_W'(r_code << fill_xbits);
        fill_idx   = fill_base + r_j[IDX_W-1:0];
        fd_sh      = 3'(r_cnt - CNT_W'(LOOKUP_BITS));
        fd_idx     = IDX_W'(r_buf >> fd_sh);
        end_sh     = 3'(CNT_W'(LOOKUP_BITS) - r_cnt);
        end_idx    = r_buf[IDX_W-1:0] << end_sh;
        rd_len     = leaf_len(rd_data);
        rd_link    = link_target(rd_data);
        fd_leaf    = (rd_data[1:0] == TAG_LEAF);
        fd_link    = (rd_data[1:0] == TAG_LINK) && (rd_link != '0);
        fd_next    = fd_leaf ? (r_cnt - {1'b0, rd_len}) : (r_cnt - CNT_W'(LOOKUP_BITS));
        end_next   = r_cnt - {1'b0, rd_len};
        used_inc   = r_used + LEVEL_W'(1);
        in_mask    = CODE_W'((33'h1 << i_item.code_length) - 33'h1);
    end

    always_comb begin
        o_stat.sweep_last    = (r_addr == ADDR_W'(DEPTH - 1));
        o_stat.len_zero      = (r_len == '0);
        o_stat.len_over      = (r_len > LEN_W'(MAX_CODE_LENGTH));
        o_stat.len_long      = (r_len > LEN_W'(LOOKUP_BITS));
        o_stat.rd_tag        = rd_data[1:0];
        o_stat.link_ok       = (rd_link != '0);
        o_stat.used_full     = (r_used >= LEVEL_W'(SUBTABLE_COUNT));
        o_stat.rem_long      = (walk_rem > LEN_W'(LOOKUP_BITS));
        o_stat.chk_bad       = r_pend && (rd_data != EMPTY_ENTRY);
        o_stat.chk_done      = (r_j == fill_count) && !r_pend;
        o_stat.wr_last       = (r_j == fill_count - (IDX_W+1)'(1));
        o_stat.fd_leaf       = fd_leaf;
        o_stat.fd_link       = fd_link;
        o_stat.fd_next_lt8   = (fd_next < CNT_W'(LOOKUP_BITS));
        o_stat.end_zero      = (r_cnt == '0);
        o_stat.end_fits      = fd_leaf && ({1'b0, rd_len} <= r_cnt);
        o_stat.end_next_zero = (end_next == '0);
        o_stat.level_top     = (r_level == '0);
    end

    // Store ports
    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = EMPTY_ENTRY;
        raddr = '0;
        case (i_cmd.op)
            OP_SWEEP: begin
                we = 1'b1;
            end
            OP_LD_RD: begin
                raddr = {r_lvl, walk_idx};
            end
            OP_LD_ALLOC: begin
                we    = 1'b1;
                waddr = {r_lvl, walk_idx};
                wdata = {{(ENTRY_W-LEVEL_W-2){1'b0}}, used_inc, TAG_LINK};
            end
            OP_CHK: begin
                raddr = {r_lvl, fill_idx};
            end
            OP_WR: begin
                we    = 1'b1;
                waddr = {r_lvl, fill_idx};
                wdata = {r_len[3:0], r_sym, TAG_LEAF};
            end
            OP_FD_RD: begin
                raddr = {r_level, fd_idx};
            end
            OP_END_RD: begin
                raddr = {r_level, end_idx};
            end
            default: begin
            end
        endcase
    end

    // Result register. A feed holds a result back by one lookup unless it is
    // already known to be final, since only a later lookup tells whether it is.
    always_comb begin
        emit_res.symbol_out = (i_cmd.status == ST_SYMBOL) ? rd_data[SYM_W+1:2] : '0;
        emit_res.status     = i_cmd.status;
        emit_res.last       = i_cmd.last;
        n_strobe = 1'b0;
        n_res    = r_res;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        case (i_cmd.op)
            OP_FD_EX: begin
                if (i_cmd.emit && r_hold_v) begin
                    n_strobe = 1'b1;
                    n_res    = r_hold;
                    n_hold   = emit_res;
                end else if (i_cmd.emit && i_cmd.last) begin
                    n_strobe = 1'b1;
                    n_res    = emit_res;
                end else if (i_cmd.emit) begin
                    n_hold   = emit_res;
                    n_hold_v = 1'b1;
                end else if (i_cmd.last && r_hold_v) begin
                    // Final lookup was a link: the held result closes the transaction
                    n_strobe      = 1'b1;
                    n_res         = r_hold;
                    n_res.last    = 1'b1;
                    n_hold_v      = 1'b0;
                end
            end
            OP_FD_FLUSH: begin
                n_strobe = r_hold_v;
                n_res    = r_hold;
                n_hold_v = 1'b0;
            end
            default: begin
                if (i_cmd.emit) begin
                    n_strobe = 1'b1;
                    n_res    = emit_res;
                end
            end
        endcase
    end

    always_comb begin
        n_addr   = r_addr;
        n_used   = r_used;
        n_level  = r_level;
        n_lvl    = r_lvl;
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_code   = r_code;
        n_len    = r_len;
        n_sym    = r_sym;
        n_j      = r_j;
        n_pend   = r_pend;
        case (i_cmd.op)
            OP_SWEEP: begin
                n_addr = r_addr + ADDR_W'(1);
            end
            OP_CAPTURE: begin
                case (i_item.command)
                    CMD_CLEAR: begin
                        n_addr  = '0;
                        n_used  = '0;
                        n_buf   = '0;
                        n_cnt   = '0;
                        n_level = '0;
                    end
                    CMD_LOAD: begin
                        n_code = i_item.code_bits & in_mask;
                        n_len  = i_item.code_length;
                        n_sym  = i_item.symbol_in;
                        n_lvl  = '0;
                        n_j    = '0;
                        n_pend = 1'b0;
                    end
                    CMD_FEED: begin
                        n_buf = {r_buf[7:0], i_item.data_byte};
                        n_cnt = {2'b00, r_cnt[2:0]} + CNT_W'(LOOKUP_BITS);
                    end
                    default: begin
                        // End of stream: look at no more than one lookup's worth
                        n_cnt = ({1'b0, r_cnt[3:0]} > CNT_W'(LOOKUP_BITS)) ?
                                CNT_W'(LOOKUP_BITS) : {1'b0, r_cnt[3:0]};
                    end
                endcase
            end
            OP_LD_ALLOC: begin
                n_used = used_inc;
                n_lvl  = used_inc;
                n_code = r_code & walk_mask;
                n_len  = walk_rem;
            end
            OP_LD_FOLLOW: begin
                n_lvl  = rd_link;
                n_code = r_code & walk_mask;
                n_len  = walk_rem;
            end
            OP_CHK: begin
                if (r_j < fill_count) begin
                    n_j    = r_j + (IDX_W+1)'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (o_stat.chk_done) begin
                    n_j = '0;
                end
            end
            OP_WR: begin
                n_j = r_j + (IDX_W+1)'(1);
            end
            OP_FD_EX: begin
                n_cnt   = fd_next;
                n_level = fd_link ? rd_link : '0;
                n_buf   = r_buf & 16'((17'h1 << fd_next) - 17'h1);
            end
            OP_END_EX: begin
                if (o_stat.end_fits && (end_next != '0)) begin
                    n_cnt   = end_next;
                    n_buf   = r_buf & 16'((17'h1 << end_next) - 17'h1);
                    n_level = '0;
                end else begin
                    n_cnt   = '0;
                    n_buf   = '0;
                    n_level = '0;
                end
            end
            OP_END_FIN: begin
                n_cnt   = '0;
                n_buf   = '0;
                n_level = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_used   <= '0;
            r_level  <= '0;
            r_buf    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_addr   <= n_addr;
            r_used   <= n_used;
            r_level  <= n_level;
            r_buf    <= n_buf;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
            r_hold_v <= n_hold_v;
        end
        r_lvl  <= n_lvl;
        r_code <= n_code;
        r_len  <= n_len;
        r_sym  <= n_sym;
        r_j    <= n_j;
        r_pend <= n_pend;
        r_res  <= n_res;
        r_hold <= n_hold;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(16))
        else $error("bit count out of range");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= LEVEL_W'(SUBTABLE_COUNT))
        else $error("subtable count out of range");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FD_FLUSH) |=> !r_hold_v)
        else $error("held result survived a flush");

endmodule

`default_nettype wire

// ----- sv/hmtd_ctrl.sv -----
// ============================================================================
// hmtd_ctrl - sequencing state machine
// Steps the datapath through clear, load, feed and end-of-stream commands.
// ============================================================================
`default_nettype none

module hmtd_ctrl
    import hmtd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic [1:0] i_command,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy
);

    t_state r_state, n_state;
    logic   r_report, n_report;
    logic   r_any, n_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_report <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
            r_any    <= n_any;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_report      = r_report;
        o_cmd.op      = OP_NONE;
        o_cmd.emit    = 1'b0;
        o_cmd.status  = ST_DONE;
        o_cmd.last    = 1'b0;
        case (r_state)
            S_SWEEP: begin
                o_cmd.op = OP_SWEEP;
                if (i_stat.sweep_last) begin
                    o_cmd.emit = r_report;
                    o_cmd.last = 1'b1;
                    n_report   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_CAPTURE;
                    case (i_command)
                        CMD_CLEAR: begin
                            n_report = 1'b1;
                            n_state  = S_SWEEP;
                        end
                        CMD_LOAD:  n_state = S_LD_START;
                        CMD_FEED:  n_state = S_FD_RD;
                        default:   n_state = S_END_START;
                    endcase
                end
            end
            S_LD_START: begin
                if (i_stat.len_zero || i_stat.len_over) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = i_stat.len_zero ? ST_DONE : ST_INVALID;
                    n_state      = S_IDLE;
                end else if (i_stat.len_long) begin
                    n_state = S_LD_RD;
                end else begin
                    n_state = S_LD_CHK;
                end
            end
            S_LD_RD: begin
                o_cmd.op = OP_LD_RD;
                n_state  = S_LD_EX;
            end
            S_LD_EX: begin
                if (i_stat.rd_tag == TAG_EMPTY && !i_stat.used_full) begin
                    o_cmd.op = OP_LD_ALLOC;
                    n_state  = i_stat.rem_long ? S_LD_RD : S_LD_CHK;
                end else if (i_stat.rd_tag == TAG_LINK && i_stat.link_ok) begin
                    o_cmd.op = OP_LD_FOLLOW;
                    n_state  = i_stat.rem_long ? S_LD_RD : S_LD_CHK;
                end else begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = (i_stat.rd_tag == TAG_EMPTY) ? ST_EXHAUSTED : ST_CLASH;
                    n_state      = S_IDLE;
                end
            end
            S_LD_CHK: begin
                o_cmd.op = OP_CHK;
                if (i_stat.chk_bad) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = ST_CLASH;
                    n_state      = S_IDLE;
                end else if (i_stat.chk_done) begin
                    n_state = S_LD_WR;
                end
            end
            S_LD_WR: begin
                o_cmd.op = OP_WR;
                if (i_stat.wr_last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FD_RD: begin
                o_cmd.op = OP_FD_RD;
                n_state  = S_FD_EX;
            end
            S_FD_EX: begin
                o_cmd.op   = OP_FD_EX;
                o_cmd.last = i_stat.fd_next_lt8;
                if (i_stat.fd_leaf) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_SYMBOL;
                end else if (i_stat.fd_link) begin
                    o_cmd.emit = i_stat.fd_next_lt8 && !r_any;
                end else begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = ST_INVALID;
                end
                // A final result behind a held one goes out through the flush state
                if (!i_stat.fd_next_lt8) begin
                    n_state = S_FD_RD;
                end else if (r_any && !i_stat.fd_link) begin
                    n_state = S_FD_FLUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FD_FLUSH: begin
                o_cmd.op = OP_FD_FLUSH;
                n_state  = S_IDLE;
            end
            S_END_START: begin
                if (i_stat.end_zero) begin
                    o_cmd.op     = OP_END_FIN;
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = i_stat.level_top ? ST_DONE : ST_INVALID;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_END_RD;
                end
            end
            S_END_RD: begin
                o_cmd.op = OP_END_RD;
                n_state  = S_END_EX;
            end
            S_END_EX: begin
                o_cmd.op   = OP_END_EX;
                o_cmd.emit = 1'b1;
                if (i_stat.end_fits) begin
                    o_cmd.status = ST_SYMBOL;
                    o_cmd.last   = i_stat.end_next_zero;
                    n_state      = i_stat.end_next_zero ? S_IDLE : S_END_RD;
                end else begin
                    o_cmd.status = ST_INVALID;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_any = (r_state == S_IDLE) ? 1'b0 : (r_any | o_cmd.emit);
    end

    assign o_busy = (r_state != S_IDLE);

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && o_cmd.last |=> (r_state == S_IDLE) || (r_state == S_FD_FLUSH))
        else $error("final result not followed by idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_start |=> o_busy)
        else $error("accepted transaction did not raise busy");

    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> r_state == S_SWEEP)
        else $error("reset did not start the clearing pass");

endmodule

`default_nettype wire

// ----- sv/multilevel_table_huffman_decoder_core.sv -----
// ============================================================================
// multilevel_table_huffman_decoder_core - table-driven Huffman decoder
// Multi-level 8-bit lookup table builder and MSB-first stream decoder.
// ============================================================================
// A transaction is accepted on a clock edge with start high and busy low.
// Results come out on o_result for one cycle each, flagged by o_strobe; the
// receiver cannot stall them, and o_result.last marks the final result of a
// transaction. After reset, and for every clear command, the block runs a
// clearing pass over the whole 16640-entry table store, one entry per cycle,
// with busy held high throughout (a clear then reports done). The store
// has one registered read port, so every table access is a read state
// followed by an execute state. A feed captures the byte and then makes up
// to 8 lookups, with a flush step when its final result follows an earlier
// one; a feed result not yet known to be final is held back by one lookup,
// since only the next lookup tells whether it closes the transaction. End
// of stream reads one leftover code at a time; a short code load checks its
// 2^(8-len) slots at one per cycle and then writes them at one per cycle,
// after a read and an execute step for each subtable level of a long code.
`default_nettype none

module multilevel_table_huffman_decoder_core
    import hmtd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_item i_item,
    output logic          busy,
    output logic          o_strobe,
    output t_out_item     o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequence the command; the datapath holds all table and bit state
    hmtd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    hmtd_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ----- tb/hmtd_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hmtd_checker - result predictor and scoreboard for the Huffman decoder
// Tracks accepted transactions, keeps its own copy of the lookup table and
// decode state, and compares every strobed result against its prediction.
// ============================================================================
module hmtd_checker
    import hmtd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_item  i_item,
    input  logic      i_strobe,
    input  t_out_item i_result,
    output int        o_errors,
    output int        o_pending
);

    logic [ENTRY_W-1:0] huff_tbl [DEPTH];
    int unsigned        tables_used;
    int unsigned        bit_buf;
    int unsigned        bit_cnt;
    int unsigned        cur_level;
    t_out_item          expected_q[$];

    task automatic table_clear();
        for (int i = 0; i < DEPTH; i++) huff_tbl[i] = EMPTY_ENTRY;
        tables_used = 0;
        bit_buf     = 0;
        bit_cnt     = 0;
        cur_level   = 0;
    endtask

    task automatic queue_result(input int unsigned sym, input t_status st);
        t_out_item r;
        r.symbol_out = sym[15:0];
        r.status     = st;
        r.last       = 1'b0;
        expected_q.push_back(r);
    endtask

    function automatic int unsigned entry_len(input logic [ENTRY_W-1:0] e);
        int unsigned l;
        l = e[21:18];
        return (l == 0 || l > 8) ? 8 : l;
    endfunction

    function automatic int unsigned entry_next(input logic [ENTRY_W-1:0] e);
        int unsigned lv;
        lv = e[8:2];
        return (lv == 0 || lv > SUBTABLE_COUNT) ? 0 : lv;
    endfunction

    task automatic predict_load(input int unsigned code, input int unsigned len,
                                input int unsigned sym, output t_status st);
        int unsigned lvl, rem, slot, xb, cnt, base;
        logic [ENTRY_W-1:0] e;
        lvl = 0;
        st  = ST_DONE;
        if (len == 0) return;
        if (len > MAX_CODE_LENGTH) begin
            st = ST_INVALID;
            return;
        end
        code &= (1 << len) - 1;
        while (len > 8) begin
            rem  = len - 8;
            slot = lvl * 256 + ((code >> rem) & 255);
            e    = huff_tbl[slot];
            if (e[1:0] == TAG_EMPTY) begin
                if (tables_used >= SUBTABLE_COUNT) begin
                    st = ST_EXHAUSTED;
                    return;
                end
                tables_used++;
                for (int j = 0; j < 256; j++) huff_tbl[tables_used * 256 + j] = EMPTY_ENTRY;
                huff_tbl[slot] = ENTRY_W'(tables_used << 2) | ENTRY_W'(TAG_LINK);
                lvl = tables_used;
            end else if (e[1:0] == TAG_LINK) begin
                lvl = entry_next(e);
                if (lvl == 0) begin
                    st = ST_CLASH;
                    return;
                end
            end else begin
                st = ST_CLASH;
                return;
            end
            code &= (1 << rem) - 1;
            len = rem;
        end
        xb   = 8 - len;
        cnt  = 1 << xb;
        base = lvl * 256 + ((code << xb) & 255);
        for (int j = 0; j < cnt; j++)
            if (huff_tbl[base + j] != EMPTY_ENTRY) begin
                st = ST_CLASH;
                return;
            end
        for (int j = 0; j < cnt; j++)
            huff_tbl[base + j] = ENTRY_W'((len << 18) | ((sym & 16'hffff) << 2))
                                 | ENTRY_W'(TAG_LEAF);
    endtask

    task automatic predict_feed(input int unsigned data);
        int unsigned idx, n0;
        logic [ENTRY_W-1:0] e;
        n0      = expected_q.size();
        bit_cnt &= 7;
        bit_buf = ((bit_buf << 8) | (data & 255)) & 16'hffff;
        bit_cnt += 8;
        while (bit_cnt >= 8) begin
            idx = (bit_buf >> (bit_cnt - 8)) & 255;
            e   = huff_tbl[cur_level * 256 + idx];
            if (e[1:0] == TAG_LEAF) begin
                queue_result(e[17:2], ST_SYMBOL);
                bit_cnt -= entry_len(e);
                cur_level = 0;
            end else if (e[1:0] == TAG_LINK && entry_next(e) != 0) begin
                bit_cnt -= 8;
                cur_level = entry_next(e);
            end else begin
                queue_result(0, ST_INVALID);
                bit_cnt -= 8;
                cur_level = 0;
            end
            bit_buf &= (1 << bit_cnt) - 1;
        end
        if (expected_q.size() == n0) queue_result(0, ST_DONE);
    endtask

    task automatic predict_end();
        int unsigned idx;
        logic [ENTRY_W-1:0] e;
        bit_cnt &= 15;
        if (bit_cnt == 0) queue_result(0, cur_level == 0 ? ST_DONE : ST_INVALID);
        while (bit_cnt > 0) begin
            if (bit_cnt > 8) bit_cnt = 8;
            idx = (bit_buf << (8 - bit_cnt)) & 255;
            e   = huff_tbl[cur_level * 256 + idx];
            if (e[1:0] == TAG_LEAF && entry_len(e) <= bit_cnt) begin
                queue_result(e[17:2], ST_SYMBOL);
                bit_cnt -= entry_len(e);
                bit_buf &= (1 << bit_cnt) - 1;
                cur_level = 0;
            end else begin
                queue_result(0, ST_INVALID);
                bit_cnt = 0;
            end
        end
        bit_buf   = 0;
        bit_cnt   = 0;
        cur_level = 0;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_status   st;
        t_out_item r;
        if (!i_rst_n) begin
            table_clear();
            expected_q.delete();
        end else begin
            // Check the result strobed in this cycle.
            if (i_strobe) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_result);
                    o_errors++;
                end else begin
                    r = expected_q.pop_front();
                    if (r.symbol_out !== i_result.symbol_out || r.status !== i_result.status
                        || r.last !== i_result.last) begin
                        $display("%0t: mismatch expected sym=%h st=%0d last=%0b actual sym=%h st=%0d last=%0b",
                                 $time, r.symbol_out, r.status, r.last,
                                 i_result.symbol_out, i_result.status, i_result.last);
                        o_errors++;
                    end
                end
            end
            // Predict an accepted transaction.
            if (i_start && !i_busy) begin
                case (t_cmd'(i_item.command))
                    CMD_CLEAR: begin
                        table_clear();
                        queue_result(0, ST_DONE);
                    end
                    CMD_LOAD: begin
                        predict_load(i_item.code_bits, i_item.code_length, i_item.symbol_in, st);
                        queue_result(0, st);
                    end
                    CMD_FEED: predict_feed(i_item.data_byte);
                    default:  predict_end();
                endcase
                r = expected_q.pop_back();
                r.last = 1'b1;
                expected_q.push_back(r);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

// ----- tb/multilevel_table_huffman_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// multilevel_table_huffman_decoder_core_tb - testbench for the Huffman decoder
// Drives directed and random table loads and stream bytes with random gaps;
// the checker predicts and compares all results, the top gives the verdict.
// ============================================================================
module multilevel_table_huffman_decoder_core_tb;
    import hmtd_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;
    int        errors;
    int        pending;
    int        sent;
    bit        no_gaps;

    multilevel_table_huffman_decoder_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    hmtd_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_item    (i_item),
        .i_strobe  (o_strobe),
        .i_result  (o_result),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: covers every clearing pass plus the slowest loads and feeds.
    initial begin
        #20ms;
        $display("multilevel_table_huffman_decoder_core_tb NOT OK");
        $finish;
    end

    // Present one transaction and hold it until the block takes it. Start
    // stays high when no idle gap follows, so a back-to-back transaction needs no toggle.
    task automatic issue(input t_cmd cmd, input int unsigned code, input int unsigned len,
                         input int unsigned sym, input int unsigned data);
        int unsigned r;
        int unsigned gap;
        i_item.command     <= cmd;
        i_item.code_bits   <= code[15:0];
        i_item.code_length <= len[4:0];
        i_item.symbol_in   <= sym[15:0];
        i_item.data_byte   <= data[7:0];
        start              <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        // Insert an idle gap: mostly none or short, now and then long.
        r   = $urandom_range(0, 99);
        gap = (no_gaps || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic do_clear();
        issue(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic do_load(input int unsigned code, input int unsigned len,
                           input int unsigned sym);
        issue(CMD_LOAD, code, len, sym, $urandom);
    endtask

    task automatic do_feed(input int unsigned data);
        issue(CMD_FEED, $urandom, $urandom, $urandom, data);
    endtask

    task automatic do_end();
        issue(CMD_END, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned code;
        int unsigned len;
        int unsigned nxt;
        int unsigned nsym;
        int unsigned nbytes;
        start   = 1'b0;
        i_item  = '0;
        sent    = 0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: short, long and broken loads, then decode across them.
        do_load(16'h0000, 1, 16'hffff);     // '0' -> all-ones symbol
        do_load(16'h0002, 2, 16'h0000);     // '10'
        do_load(16'h1234, 0, 16'h5555);     // skipped entry
        do_load(16'hffff, 31, 16'haaaa);    // overlong entry
        do_load(16'hff0c, 4, 16'h00c3);     // stray high bits, code '1100'
        do_load(16'h0004, 3, 16'h0001);     // clash on '10'
        do_load(16'hffa3, 16, 16'h8001);    // longest code, one link
        do_load(16'h01c1, 9, 16'h7e7e);     // opens a second subtable
        do_load(16'h0012, 12, 16'h0202);    // path meets a leaf
        do_feed(8'h00);                     // eight 1-bit symbols
        do_feed(8'hff);
        do_feed(8'ha3);
        do_feed(8'hd0);                     // empty slot
        do_feed(8'he0);
        do_feed(8'hc0);
        do_end();                           // leftover bits zero padded
        do_feed(8'hff);
        do_end();                           // unfinished long code
        do_end();                           // nothing left
        do_feed(8'h83);
        do_end();
        drain();

        // Exhaust the subtables with nine-bit codes on distinct first bytes.
        do_clear();
        no_gaps = 1'b1;
        for (int i = 0; i <= SUBTABLE_COUNT; i++)
            do_load((i << 1) | $urandom_range(0, 1), 9, $urandom);
        no_gaps = 1'b0;
        for (int i = 0; i < 6; i++) do_feed($urandom);
        do_end();
        drain();

        // Random phases: a prefix-free code set, then a stream through it.
        while (sent < 350) begin
            do_clear();
            no_gaps = ($urandom_range(0, 3) == 0);
            code = 0;
            len  = $urandom_range(1, 5);
            nsym = $urandom_range(3, 14);
            for (int s = 0; s < nsym && code < (1 << len); s++) begin
                if ($urandom_range(0, 9) == 0)
                    do_load($urandom, $urandom_range(0, 31), $urandom);
                do_load(code | ($urandom << len), len, $urandom);
                code++;
                nxt = (len >= 16) ? 16 :
                      ($urandom_range(0, 5) == 0) ? 16 : len + $urandom_range(0, 2);
                if (nxt > 16) nxt = 16;
                code = code << (nxt - len);
                len  = nxt;
            end
            nbytes = $urandom_range(6, 24);
            for (int b = 0; b < nbytes; b++) begin
                if ($urandom_range(0, 11) == 0) do_end();
                do_feed($urandom);
            end
            do_end();
            if ($urandom_range(0, 2) == 0) drain();
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("multilevel_table_huffman_decoder_core_tb OK");
        end else begin
            $display("multilevel_table_huffman_decoder_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hmtd_pkg.sv
sv/hmtd_ram.sv
sv/hmtd_datapath.sv
sv/hmtd_ctrl.sv
sv/multilevel_table_huffman_decoder_core.sv
tb/hmtd_checker.sv
tb/multilevel_table_huffman_decoder_core_tb.sv
